// File: hw/rtl/aeet_pkg.sv
// Shared types and constants of the ADC endstop EMA trigger core.
// No dependencies; used by every other file of the block.
package aeet_pkg;

  localparam int unsigned AccW    = 64;
  localparam int unsigned ValW    = 32;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned CountW  = 8;
  localparam int unsigned ReasonW = 8;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned FaultW  = 2;
  localparam int unsigned DbW     = 31;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [AccW-1:0] AccHalf = {1'b1, {(AccW-1){1'b0}}};

  localparam logic [FaultW-1:0] FaultNone    = 2'd0;
  localparam logic [FaultW-1:0] FaultSensor  = 2'd1;
  localparam logic [FaultW-1:0] FaultStopped = 2'd2;

  typedef enum logic [CmdW-1:0] {
    CmdSample    = 3'd0,
    CmdReinit    = 3'd1,
    CmdArm       = 3'd2,
    CmdSensorErr = 3'd3,
    CmdSrcStop   = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegDeadband  = 3'd0,
    RegSetpoint  = 3'd1,
    RegTrendLow  = 3'd2,
    RegTrendHigh = 3'd3,
    RegFastShift = 3'd4,
    RegSlowShift = 3'd5,
    RegConfirm   = 3'd6,
    RegReason    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [DbW-1:0]     deadband;
    logic [ValW-1:0]    setpoint;
    logic [ValW-1:0]    trend_low;
    logic [ValW-1:0]    trend_high;
    logic [ShiftW-1:0]  fast_shift;
    logic [ShiftW-1:0]  slow_shift;
    logic [CountW-1:0]  confirm_count;
    logic [ReasonW-1:0] reason_code;
  } cfg_t;

endpackage

// File: hw/rtl/adc_endstop_ema_trigger_core.sv
// A request is accepted into the input register and computed from there into the result
// register, from which it is offered on m_axis; an m_axis stall holds it in the input register.
// Throughput: one request per cycle while m_axis does not stall; the whole filter and trigger
// update of a request is done combinationally between the input and the result register.
// Reset (rst_ni low, asynchronous) empties both registers, puts both filters at zero,
// clears all flags and counters, and restores the register defaults.
module adc_endstop_ema_trigger_core #(
  parameter int unsigned OutDataW = 176
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [aeet_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [aeet_pkg::ValW-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: sample[31:0], ticks[63:32].
  input  logic [2*aeet_pkg::ValW-1:0]   s_axis_tdata,
  // Fields from bit 0: command[2:0].
  input  logic [aeet_pkg::CmdW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: trigger_fire[0], fire_reason[8:1], fault[10:9],
  // homing_active[11], trig_latched[12], trigger_time[44:13], latest_sample[76:45],
  // latest_ticks[108:77], fast_average[140:109], slow_average[172:141], zero pad.
  output logic [OutDataW-1:0]           m_axis_tdata
);

  localparam int unsigned ResW = 5 * aeet_pkg::ValW + aeet_pkg::ReasonW
                                 + aeet_pkg::FaultW + 3;

  aeet_pkg::cfg_t cfg;

  aeet_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register.
  logic                        in_valid_q;
  logic [aeet_pkg::CmdW-1:0]   in_cmd_q;
  logic [aeet_pkg::ValW-1:0]   in_sample_q, in_ticks_q;
  logic                        out_valid_q;
  logic                        advance, proc;

  assign advance       = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q    <= s_axis_tuser;
      in_sample_q <= s_axis_tdata[aeet_pkg::ValW-1:0];
      in_ticks_q  <= s_axis_tdata[2*aeet_pkg::ValW-1:aeet_pkg::ValW];
    end
  end

  // Detector state.
  logic [aeet_pkg::AccW-1:0]   fast_acc_q, fast_acc_d, slow_acc_q, slow_acc_d;
  logic [aeet_pkg::ValW-1:0]   fast_avg_q, fast_avg_d, slow_avg_q, slow_avg_d;
  logic [aeet_pkg::CountW-1:0] remain_q, remain_d;
  logic                        homing_q, homing_d, trig_flag_q, trig_flag_d;
  logic [aeet_pkg::ValW-1:0]   trig_time_q, trig_time_d;
  logic [aeet_pkg::ValW-1:0]   last_val_q, last_val_d, last_ticks_q, last_ticks_d;

  logic [aeet_pkg::AccW-1:0]   fast_step_acc, fast_init_acc, slow_step_acc, slow_init_acc;
  logic [aeet_pkg::ValW-1:0]   fast_step_avg, slow_step_avg;

  aeet_ema_step u_fast (
    .acc_i      (fast_acc_q),
    .sample_i   (in_sample_q),
    .setpoint_i (cfg.setpoint),
    .shift_i    (cfg.fast_shift),
    .step_acc_o (fast_step_acc),
    .step_avg_o (fast_step_avg),
    .init_acc_o (fast_init_acc)
  );

  aeet_ema_step u_slow (
    .acc_i      (slow_acc_q),
    .sample_i   (in_sample_q),
    .setpoint_i (cfg.setpoint),
    .shift_i    (cfg.slow_shift),
    .step_acc_o (slow_step_acc),
    .step_avg_o (slow_step_avg),
    .init_acc_o (slow_init_acc)
  );

  logic signed [aeet_pkg::ValW+1:0] fa_w, ta_w, db_w;
  logic                             band_out, trend_out, fire;
  logic [aeet_pkg::FaultW-1:0]      fault;

  always_comb begin
    fa_w      = (aeet_pkg::ValW+2)'($signed(fast_step_avg));
    ta_w      = (aeet_pkg::ValW+2)'($signed(slow_avg_q));
    db_w      = (aeet_pkg::ValW+2)'(cfg.deadband);
    band_out  = (fa_w > ta_w + db_w) || (fa_w < ta_w - db_w);
    trend_out = ($signed(slow_step_avg) > $signed(cfg.trend_high))
             || ($signed(slow_step_avg) < $signed(cfg.trend_low));

    fast_acc_d   = fast_acc_q;
    slow_acc_d   = slow_acc_q;
    fast_avg_d   = fast_avg_q;
    slow_avg_d   = slow_avg_q;
    remain_d     = remain_q;
    homing_d     = homing_q;
    trig_flag_d  = trig_flag_q;
    trig_time_d  = trig_time_q;
    last_val_d   = last_val_q;
    last_ticks_d = last_ticks_q;
    fire         = 1'b0;
    fault        = aeet_pkg::FaultNone;

    unique case (in_cmd_q)
      aeet_pkg::CmdSample: begin
        last_val_d   = in_sample_q;
        last_ticks_d = in_ticks_q;
        fast_acc_d   = fast_step_acc;
        fast_avg_d   = fast_step_avg;
        if (band_out && remain_q != '0) begin
          if (homing_q && remain_q == cfg.confirm_count) begin
            trig_time_d = in_ticks_q;
          end
          remain_d = remain_q - 1'b1;
          if (remain_q == aeet_pkg::CountW'(1)) begin
            trig_flag_d = 1'b1;
            if (homing_q) begin
              fire     = 1'b1;
              homing_d = 1'b0;
            end
          end
        end else if (!band_out && remain_q < cfg.confirm_count) begin
          remain_d    = cfg.confirm_count;
          trig_flag_d = 1'b0;
          if (homing_q) begin
            trig_time_d = '0;
          end
        end
        if (!band_out) begin
          slow_acc_d = slow_step_acc;
          slow_avg_d = slow_step_avg;
          if (trend_out) begin
            trig_flag_d = 1'b1;
            if (homing_q) begin
              fire     = 1'b1;
              homing_d = 1'b0;
            end
          end
        end
      end
      aeet_pkg::CmdReinit: begin
        fast_acc_d = fast_init_acc;
        slow_acc_d = slow_init_acc;
      end
      aeet_pkg::CmdArm: begin
        if (cfg.confirm_count == '0) begin
          homing_d = 1'b0;
        end else begin
          remain_d = cfg.confirm_count;
          homing_d = 1'b1;
        end
      end
      aeet_pkg::CmdSensorErr: begin
        if (homing_q) begin
          fire  = 1'b1;
          fault = aeet_pkg::FaultSensor;
        end
      end
      aeet_pkg::CmdSrcStop: begin
        if (homing_q) begin
          fire  = 1'b1;
          fault = aeet_pkg::FaultStopped;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_acc_q   <= aeet_pkg::AccHalf;
      slow_acc_q   <= aeet_pkg::AccHalf;
      fast_avg_q   <= '0;
      slow_avg_q   <= '0;
      remain_q     <= '0;
      homing_q     <= 1'b0;
      trig_flag_q  <= 1'b0;
      trig_time_q  <= '0;
      last_val_q   <= '0;
      last_ticks_q <= '0;
    end else if (proc) begin
      fast_acc_q   <= fast_acc_d;
      slow_acc_q   <= slow_acc_d;
      fast_avg_q   <= fast_avg_d;
      slow_avg_q   <= slow_avg_d;
      remain_q     <= remain_d;
      homing_q     <= homing_d;
      trig_flag_q  <= trig_flag_d;
      trig_time_q  <= trig_time_d;
      last_val_q   <= last_val_d;
      last_ticks_q <= last_ticks_d;
    end
  end

  // Result register.
  logic [ResW-1:0] res_q, res_d;

  assign res_d = {slow_avg_d, fast_avg_d, last_ticks_d, last_val_d, trig_time_d,
                  trig_flag_d, homing_d, fault,
                  fire ? cfg.reason_code : {aeet_pkg::ReasonW{1'b0}}, fire};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(res_q);

`ifndef SYNTHESIS
  a_fault_fires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q[10:9] != aeet_pkg::FaultNone |-> res_q[0] && res_q[10:9] != 2'd3)
    else $error("fault reported without a fired trigger");

  a_homing_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(homing_q) |-> $past(proc) && $past(in_cmd_q) == aeet_pkg::CmdArm)
    else $error("homing armed without an arm request");

  a_sample_fire_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && fire && fault == aeet_pkg::FaultNone |=> !homing_q && trig_flag_q)
    else $error("sample trigger did not disarm homing");

  a_no_fire_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && !homing_q |-> !fire)
    else $error("trigger fired while not homing");
`endif

endmodule

// File: hw/rtl/aeet_cfg_regs.sv
// Configuration register file of the ADC endstop EMA trigger core.
// Depends on aeet_pkg for the register index codes and the cfg_t bundle.
module aeet_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [aeet_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [aeet_pkg::ValW-1:0]    cfg_data_i,
  output aeet_pkg::cfg_t               cfg_o
);

  localparam aeet_pkg::cfg_t CfgReset = '{
    deadband:      '0,
    setpoint:      '0,
    trend_low:     {1'b1, {(aeet_pkg::ValW-1){1'b0}}},
    trend_high:    {1'b0, {(aeet_pkg::ValW-1){1'b1}}},
    fast_shift:    '0,
    slow_shift:    '0,
    confirm_count: '0,
    reason_code:   '0
  };

  aeet_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (aeet_pkg::cfg_idx_e'(cfg_index_i))
        aeet_pkg::RegDeadband:  cfg_d.deadband      = cfg_data_i[aeet_pkg::DbW-1:0];
        aeet_pkg::RegSetpoint:  cfg_d.setpoint      = cfg_data_i;
        aeet_pkg::RegTrendLow:  cfg_d.trend_low     = cfg_data_i;
        aeet_pkg::RegTrendHigh: cfg_d.trend_high    = cfg_data_i;
        aeet_pkg::RegFastShift: cfg_d.fast_shift    = cfg_data_i[aeet_pkg::ShiftW-1:0];
        aeet_pkg::RegSlowShift: cfg_d.slow_shift    = cfg_data_i[aeet_pkg::ShiftW-1:0];
        aeet_pkg::RegConfirm:   cfg_d.confirm_count = cfg_data_i[aeet_pkg::CountW-1:0];
        aeet_pkg::RegReason:    cfg_d.reason_code   = cfg_data_i[aeet_pkg::ReasonW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: hw/rtl/aeet_ema_step.sv
// One update of an offset-binary EMA accumulator, plus its reload value from a setpoint.
// Depends on aeet_pkg for widths and the offset constant.
module aeet_ema_step (
  input  logic [aeet_pkg::AccW-1:0]   acc_i,
  input  logic [aeet_pkg::ValW-1:0]   sample_i,
  input  logic [aeet_pkg::ValW-1:0]   setpoint_i,
  input  logic [aeet_pkg::ShiftW-1:0] shift_i,
  output logic [aeet_pkg::AccW-1:0]   step_acc_o,
  output logic [aeet_pkg::ValW-1:0]   step_avg_o,
  output logic [aeet_pkg::AccW-1:0]   init_acc_o
);

  logic [aeet_pkg::AccW-1:0] smp_ext, sp_ext, sum, half, avg;

  always_comb begin
    smp_ext    = {{(aeet_pkg::AccW-aeet_pkg::ValW){sample_i[aeet_pkg::ValW-1]}}, sample_i};
    sp_ext     = {{(aeet_pkg::AccW-aeet_pkg::ValW){setpoint_i[aeet_pkg::ValW-1]}}, setpoint_i};
    // Rounding term is half an LSB of the shifted value, zero for no shift.
    half       = (aeet_pkg::AccW'(1) << shift_i) >> 1;
    sum        = acc_i + smp_ext;
    avg        = ((sum + half) >> shift_i) - (aeet_pkg::AccHalf >> shift_i);
    step_acc_o = sum - avg;
    step_avg_o = avg[aeet_pkg::ValW-1:0];
    init_acc_o = aeet_pkg::AccHalf + (sp_ext << shift_i) - sp_ext;
  end

endmodule
